>>> rtl/hwfft_pkg.sv
// ----------------------------------------------------------------------------
// hwfft_pkg
// Shared constants, cosine table and small helpers for the windowed FFT.
// ----------------------------------------------------------------------------
package hwfft_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_LOG2   = $clog2(MAX_POINTS);
  localparam int AW         = 6;    // store address width (cosine table resolution)
  localparam int SW         = 23;   // stored and output sample width
  localparam int CW         = 17;   // signed cosine width

  localparam logic signed [SW-1:0] SAT_MAX = 23'sh3FFFFF;
  localparam logic signed [SW-1:0] SAT_MIN = -23'sh400000;
  localparam logic signed [17:0]   WIN_A   = 18'sd17641;
  localparam logic signed [16:0]   WIN_B   = 17'sd15127;

  // quarter wave of cos(2 pi k / 64) in q1.15
  localparam logic [15:0] QUARTER_COS [17] = '{
    16'd32767, 16'd32610, 16'd32138, 16'd31357, 16'd30274, 16'd28899,
    16'd27246, 16'd25330, 16'd23170, 16'd20788, 16'd18205, 16'd15447,
    16'd12540, 16'd9512,  16'd6393,  16'd3212,  16'd0
  };

  // full wave cosine from the quarter table
  function automatic logic signed [CW-1:0] rom_cos(input logic [AW-1:0] k);
    logic signed [CW-1:0] v;
    v = '0;
    if (k <= 6'd16) begin
      v = $signed({1'b0, QUARTER_COS[5'(k)]});
    end else if (k <= 6'd32) begin
      v = -$signed({1'b0, QUARTER_COS[5'(6'd32 - k)]});
    end else if (k <= 6'd48) begin
      v = -$signed({1'b0, QUARTER_COS[5'(k - 6'd32)]});
    end else begin
      v = $signed({1'b0, QUARTER_COS[5'(7'd64 - {1'b0, k})]});
    end
    return v;
  endfunction

  // saturate a 27-bit value to the stored width
  function automatic logic signed [SW-1:0] sat23(input logic signed [26:0] v);
    logic signed [SW-1:0] r;
    if (v > 27'(SAT_MAX)) begin
      r = SAT_MAX;
    end else if (v < 27'(SAT_MIN)) begin
      r = SAT_MIN;
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/hwfft_bfly.sv
// ----------------------------------------------------------------------------
// hwfft_bfly
// Radix-2 butterfly: registered twiddle products, then round, add and saturate.
// ----------------------------------------------------------------------------
module hwfft_bfly (
  input  logic                              clk_i,
  input  logic                              mul_en_i,
  input  logic signed [hwfft_pkg::SW-1:0]   a_re_i,
  input  logic signed [hwfft_pkg::SW-1:0]   a_im_i,
  input  logic signed [hwfft_pkg::SW-1:0]   b_re_i,
  input  logic signed [hwfft_pkg::SW-1:0]   b_im_i,
  input  logic        [hwfft_pkg::AW-1:0]   tw_i,
  output logic signed [hwfft_pkg::SW-1:0]   sum_re_o,
  output logic signed [hwfft_pkg::SW-1:0]   sum_im_o,
  output logic signed [hwfft_pkg::SW-1:0]   dif_re_o,
  output logic signed [hwfft_pkg::SW-1:0]   dif_im_o
);
  import hwfft_pkg::*;

  logic signed [CW-1:0] cos_w, sin_w;
  logic signed [39:0]   p_rc_q, p_id_q, p_rd_q, p_ic_q;
  logic signed [40:0]   t_re_full, t_im_full;
  logic signed [25:0]   t_re, t_im;

  // twiddle is cos - j sin, sin taken from the table three quarter turns on
  assign cos_w = rom_cos(tw_i);
  assign sin_w = -rom_cos(tw_i + 6'd48);

  // product registers
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      p_rc_q <= 40'(b_re_i * cos_w);
      p_id_q <= 40'(b_im_i * sin_w);
      p_rd_q <= 40'(b_re_i * sin_w);
      p_ic_q <= 40'(b_im_i * cos_w);
    end
  end

  // round to nearest, ties up; unit twiddle bypasses the products
  always_comb begin
    t_re_full = 41'(p_rc_q) - 41'(p_id_q) + 41'sd16384;
    t_im_full = 41'(p_rd_q) + 41'(p_ic_q) + 41'sd16384;
    if (tw_i == '0) begin
      t_re = 26'(b_re_i);
      t_im = 26'(b_im_i);
    end else begin
      t_re = t_re_full[40:15];
      t_im = t_im_full[40:15];
    end
  end

  assign sum_re_o = sat23(27'(a_re_i) + 27'(t_re));
  assign sum_im_o = sat23(27'(a_im_i) + 27'(t_im));
  assign dif_re_o = sat23(27'(a_re_i) - 27'(t_re));
  assign dif_im_o = sat23(27'(a_im_i) - 27'(t_im));

endmodule

>>> rtl/hamming_windowed_radix2_fft.sv
// ----------------------------------------------------------------------------
// hamming_windowed_radix2_fft
// Hamming-windowed forward radix-2 FFT over frames of stereo sample pairs.
// ----------------------------------------------------------------------------
// Usage: each slave transaction carries one stereo pair (left = real, right =
// imaginary). The pair is windowed and written to the frame store at its
// bit-reversed address before the next pair is taken. Once N = 2^size_log2
// pairs are in, the slave side is held off while the in-place transform runs:
// log2(N) * N/2 butterflies, each in read, multiply, sum-write and
// difference-write states, the two writes apart since the frame store has a
// single write port. The N bins then leave on the master side in natural
// order, tlast on bin N-1, each read from the store and then shown.
// A stalled receiver simply holds the current bin in the output register.
// Reset sets size_log2 to 6 and empties the frame; the store needs no clearing.
// A write on the configuration channel sets size_log2 (clamped to 1..6) and
// drops any partial frame; it is taken only while the block waits for input,
// and a pending write holds off the slave side for that cycle.
// ----------------------------------------------------------------------------
module hamming_windowed_radix2_fft (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,     // size_log2
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // left_sample[15:0], right_sample[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // bin_index[5:0], bin_real[28:6], bin_imag[51:29]
  output logic        m_axis_tlast
);
  import hwfft_pkg::*;

  typedef enum logic [3:0] {
    ST_LOAD, ST_WIN, ST_WSTORE, ST_BF_RD, ST_BF_MUL, ST_BF_SUM, ST_BF_WRB,
    ST_OUT_RD, ST_OUT_SHOW
  } state_e;

  state_e               state_q;
  logic [2:0]           size_q;
  logic [AW:0]          fill_q;
  logic [AW-1:0]        pos_q;
  logic signed [15:0]   x_re_q, x_im_q;
  logic [15:0]          w_q;
  logic [2:0]           stage_q;
  logic [AW-2:0]        bf_q;
  logic [AW-1:0]        k_q;
  logic signed [SW-1:0] dif_re_q, dif_im_q;

  // frame store
  logic [2*SW-1:0]      mem [MAX_POINTS];
  logic [2*SW-1:0]      rd_a_q, rd_b_q;
  logic                 rd_en;
  logic [AW-1:0]        raddr_a, raddr_b;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [2*SW-1:0]      wdata;

  logic [2:0]           lg;
  logic [AW-1:0]        n_m1, half, mask, j, a_addr, b_addr, tw, brev_pos;
  logic [AW-2:0]        bf_last;
  logic signed [CW-1:0] win_cos;
  logic signed [32:0]   win_prod;
  logic signed [17:0]   win_r, win_w;
  logic signed [33:0]   xw_re, xw_im;
  logic signed [SW-1:0] ws_re, ws_im;
  logic signed [SW-1:0] sum_re, sum_im, dif_re, dif_im;

  // active length, clamped
  always_comb begin
    lg = size_q;
    if (lg < 3'd1) lg = 3'd1;
    if (lg > 3'(MAX_LOG2)) lg = 3'(MAX_LOG2);
  end
  assign n_m1    = AW'((7'd1 << lg) - 7'd1);
  assign bf_last = (AW-1)'((6'd1 << (lg - 3'd1)) - 6'd1);

  // butterfly addressing: insert a zero bit at stage-1 into the counter
  always_comb begin
    half   = AW'(1) << (stage_q - 3'd1);
    mask   = half - AW'(1);
    j      = {1'b0, bf_q} & mask;
    a_addr = (({1'b0, bf_q} & ~mask) << 1) | j;
    b_addr = a_addr | half;
    tw     = j << (3'(AW) - stage_q);
  end

  // bit-reversed write address of the incoming pair
  always_comb begin
    for (int i = 0; i < AW; i++) brev_pos[i] = pos_q[AW-1-i];
    brev_pos = brev_pos >> (3'(AW) - lg);
  end

  // hamming coefficient: w = 17641 - round(15127 c), capped at 32767
  always_comb begin
    win_cos  = rom_cos(AW'(pos_q << (3'(AW) - lg)));
    win_prod = 33'(WIN_B * win_cos) + 33'sd16384;
    win_r    = 18'(win_prod[32:15]);
    win_w    = WIN_A - win_r;
    if (win_w > 18'sd32767) win_w = 18'sd32767;
  end

  // windowed sample, rounded
  always_comb begin
    xw_re = 34'(x_re_q * $signed({1'b0, w_q})) + 34'sd16384;
    xw_im = 34'(x_im_q * $signed({1'b0, w_q})) + 34'sd16384;
    ws_re = SW'($signed(xw_re[33:15]));
    ws_im = SW'($signed(xw_im[33:15]));
  end

  hwfft_bfly u_bfly (
    .clk_i    (clk_i),
    .mul_en_i (state_q == ST_BF_MUL),
    .a_re_i   (rd_a_q[SW-1:0]),
    .a_im_i   (rd_a_q[2*SW-1:SW]),
    .b_re_i   (rd_b_q[SW-1:0]),
    .b_im_i   (rd_b_q[2*SW-1:SW]),
    .tw_i     (tw),
    .sum_re_o (sum_re),
    .sum_im_o (sum_im),
    .dif_re_o (dif_re),
    .dif_im_o (dif_im)
  );

  // store port control
  always_comb begin
    rd_en   = (state_q == ST_BF_RD) || (state_q == ST_OUT_RD);
    raddr_a = (state_q == ST_OUT_RD) ? k_q : a_addr;
    raddr_b = b_addr;
    we      = 1'b0;
    waddr   = a_addr;
    wdata   = {sum_im, sum_re};
    case (state_q)
      ST_WSTORE: begin
        we    = 1'b1;
        waddr = brev_pos;
        wdata = {ws_im, ws_re};
      end
      ST_BF_SUM: we = 1'b1;
      ST_BF_WRB: begin
        we    = 1'b1;
        waddr = b_addr;
        wdata = {dif_im_q, dif_re_q};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) begin
      rd_a_q <= mem[raddr_a];
      rd_b_q <= mem[raddr_b];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      size_q   <= 3'(MAX_LOG2);
      fill_q   <= '0;
      pos_q    <= '0;
      x_re_q   <= '0;
      x_im_q   <= '0;
      w_q      <= '0;
      stage_q  <= 3'd1;
      bf_q     <= '0;
      k_q      <= '0;
      dif_re_q <= '0;
      dif_im_q <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          // size change drops the partial frame
          if (cfg_valid_i) begin
            size_q <= cfg_data_i;
            fill_q <= '0;
          end else if (s_axis_tvalid) begin
            x_re_q  <= s_axis_tdata[15:0];
            x_im_q  <= s_axis_tdata[31:16];
            pos_q   <= fill_q[AW-1:0];
            state_q <= ST_WIN;
          end
        end
        ST_WIN: begin
          w_q     <= 16'(win_w);
          state_q <= ST_WSTORE;
        end
        ST_WSTORE: begin
          if (pos_q == n_m1) begin
            fill_q  <= '0;
            stage_q <= 3'd1;
            bf_q    <= '0;
            state_q <= ST_BF_RD;
          end else begin
            fill_q  <= {1'b0, pos_q} + 7'd1;
            state_q <= ST_LOAD;
          end
        end
        ST_BF_RD:  state_q <= ST_BF_MUL;
        ST_BF_MUL: state_q <= ST_BF_SUM;
        ST_BF_SUM: begin
          dif_re_q <= dif_re;
          dif_im_q <= dif_im;
          state_q  <= ST_BF_WRB;
        end
        ST_BF_WRB: begin
          if (bf_q == bf_last) begin
            bf_q <= '0;
            if (stage_q == lg) begin
              k_q     <= '0;
              state_q <= ST_OUT_RD;
            end else begin
              stage_q <= stage_q + 3'd1;
              state_q <= ST_BF_RD;
            end
          end else begin
            bf_q    <= bf_q + (AW-1)'(1);
            state_q <= ST_BF_RD;
          end
        end
        ST_OUT_RD: state_q <= ST_OUT_SHOW;
        ST_OUT_SHOW: begin
          if (m_axis_tready) begin
            if (k_q == n_m1) begin
              state_q <= ST_LOAD;
            end else begin
              k_q     <= k_q + AW'(1);
              state_q <= ST_OUT_RD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign cfg_ready_o   = (state_q == ST_LOAD);
  assign s_axis_tready = (state_q == ST_LOAD) && !cfg_valid_i;
  assign m_axis_tvalid = (state_q == ST_OUT_SHOW);
  assign m_axis_tlast  = (k_q == n_m1);
  assign m_axis_tdata  = {4'd0, rd_a_q[2*SW-1:SW], rd_a_q[SW-1:0], k_q};

  // input and output sides never open together
  a_sides_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output open in the same cycle");

  // the store is never written while a bin is on offer
  a_no_write_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !we)
    else $error("frame store written during output");

  // after the last bin leaves the block waits for input again
  a_reload_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> cfg_ready_o)
    else $error("no return to loading after last bin");

endmodule

>>> test/hamming_windowed_radix2_fft_test.sv
// ----------------------------------------------------------------------------
// hamming_windowed_radix2_fft_test
// Streams stereo pairs through the windowed FFT under several transform
// lengths, predicts every bin in the scoreboard and compares field by field.
// ----------------------------------------------------------------------------
module hamming_windowed_radix2_fft_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hwfft_pkg::*;

  localparam int IDLE_PCT   = 22;
  localparam int STALL_MAX  = 6000;
  localparam int CFG_SETTLE = 40;

  typedef struct {
    logic [5:0]         index;
    logic signed [22:0] re;
    logic signed [22:0] im;
    logic               last;
  } bin_t;

  // bin predictor and store of expected bins
  class fft_scoreboard;
    bin_t               bins_due[$];
    logic signed [22:0] frame_re [64];
    logic signed [22:0] frame_im [64];
    int                 fill;
    logic [2:0]         size_code;
    int                 errors;

    function new();
      size_code = 3'd6;
      fill      = 0;
      errors    = 0;
    endfunction

    function void report(string what, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
    endfunction

    function void take_size(logic [2:0] code);
      size_code = code;
      fill      = 0;
    endfunction

    function int eff_log2();
      int l;
      l = size_code;
      if (l < 1) l = 1;
      if (l > MAX_LOG2) l = MAX_LOG2;
      return l;
    endfunction

    // q1.15 cosine of 2 pi k / 64
    function longint cosine(int k);
      int qc [17];
      qc = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
             20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
      k = k & 63;
      if (k <= 16) return qc[k];
      if (k <= 32) return -qc[32 - k];
      if (k <= 48) return -qc[k - 32];
      return qc[64 - k];
    endfunction

    // round to nearest, ties upward
    function longint rnd15(longint v);
      return (v + 64'sd16384) >>> 15;
    endfunction

    function logic signed [22:0] clip(longint v);
      if (v > 4194303) return 23'sh3FFFFF;
      if (v < -4194304) return -23'sh400000;
      return v[22:0];
    endfunction

    function void transform(int lg);
      int n, r, len, half, a, b, m;
      longint c, d, tr, ti, ar, ai, br, bi;
      logic signed [22:0] tmp;
      n = 1 << lg;
      // bit-reversed reorder
      for (int i = 0; i < n; i++) begin
        r = 0;
        for (int k = 0; k < lg; k++) r = (r << 1) | ((i >> k) & 1);
        if (r > i) begin
          tmp = frame_re[i]; frame_re[i] = frame_re[r]; frame_re[r] = tmp;
          tmp = frame_im[i]; frame_im[i] = frame_im[r]; frame_im[r] = tmp;
        end
      end
      // butterfly passes
      for (int stage = 1; stage <= lg; stage++) begin
        len  = 1 << stage;
        half = len >> 1;
        for (int base = 0; base < n; base += len) begin
          for (int j = 0; j < half; j++) begin
            a  = base + j;
            b  = a + half;
            m  = (j << (6 - stage)) & 63;
            br = frame_re[b];
            bi = frame_im[b];
            if (m == 0) begin
              tr = br;
              ti = bi;
            end else begin
              c  = cosine(m);
              d  = -cosine(m + 48);
              tr = rnd15(br * c - bi * d);
              ti = rnd15(br * d + bi * c);
            end
            ar = frame_re[a];
            ai = frame_im[a];
            frame_re[a] = clip(ar + tr);
            frame_im[a] = clip(ai + ti);
            frame_re[b] = clip(ar - tr);
            frame_im[b] = clip(ai - ti);
          end
        end
      end
    endfunction

    // window the accepted pair and predict the bins once the frame is full
    function void note_pair(logic signed [15:0] left, logic signed [15:0] right);
      int     lg, n, pos;
      longint w;
      bin_t   e;
      lg  = eff_log2();
      n   = 1 << lg;
      pos = fill & 63;
      w   = 17641 - rnd15(15127 * cosine((pos << (6 - lg)) & 63));
      if (w > 32767) w = 32767;
      frame_re[pos] = clip(rnd15(longint'(left) * w));
      frame_im[pos] = clip(rnd15(longint'(right) * w));
      fill = pos + 1;
      if (fill < n) return;
      fill = 0;
      transform(lg);
      for (int k = 0; k < n; k++) begin
        e.index = k[5:0];
        e.re    = frame_re[k];
        e.im    = frame_im[k];
        e.last  = (k == n - 1);
        bins_due.push_back(e);
      end
    endfunction

    function void check_bin(logic [55:0] data, logic last);
      bin_t e;
      if (bins_due.size() == 0) begin
        report("unexpected bin index", data[5:0], -1);
        return;
      end
      e = bins_due.pop_front();
      if (data[5:0] != e.index) report("bin_index", data[5:0], e.index);
      if ($signed(data[28:6]) != e.re) report("bin_real", $signed(data[28:6]), e.re);
      if ($signed(data[51:29]) != e.im) report("bin_imag", $signed(data[51:29]), e.im);
      if (last != e.last) report("last_bin", last, e.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // left_sample[15:0], right_sample[31:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // bin_index[5:0], bin_real[28:6], bin_imag[51:29]
  logic        m_axis_tlast;

  fft_scoreboard sb;
  bit            idle_on;
  int            quiet_cycles;

  hamming_windowed_radix2_fft i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // receiver: check each bin transaction, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_bin(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_MAX) begin
      $display("watchdog expired");
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic drain();
    while (sb.bins_due.size() > 0) @(posedge clk_i);
  endtask

  task automatic write_size(logic [2:0] code);
    drain();
    repeat (CFG_SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= code;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.take_size(code);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pair(logic signed [15:0] left, logic signed [15:0] right);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right, left};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pair(left, right);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_pair(16'($urandom), 16'($urandom));
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    sb            = new();
    idle_on       = 1'b1;
    quiet_cycles  = 0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset length of 64: field extremes first, then random fill
    send_pair(16'sh7FFF, -16'sh8000);
    send_pair(-16'sh8000, 16'sh7FFF);
    send_pair(16'sh0000, 16'sh0000);
    send_pair(-16'sh0001, 16'sh0001);
    send_pair(16'sh0001, -16'sh0001);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(-16'sh8000, -16'sh8000);
    send_pair(16'sh5555, 16'shAAAA);
    send_pair(16'shAAAA, 16'sh5555);
    send_random(55);

    // length code zero acts as two points: field extremes, then random pairs
    write_size(3'd0);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(-16'sh8000, 16'sh7FFF);
    send_pair(16'sh7FFF, -16'sh8000);
    send_random(4);

    // code seven clamps to 64, no idling on either side
    write_size(3'd7);
    idle_on = 1'b0;
    send_random(64);
    idle_on = 1'b1;
    // partial frame dropped by the next write
    send_random(4);

    write_size(3'd3);
    send_random(8);
    drain();
    send_random(8);

    write_size(3'd2);
    send_random(8);
    write_size(3'd4);
    send_random(16);

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.bins_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/hwfft_pkg.sv
rtl/hwfft_bfly.sv
rtl/hamming_windowed_radix2_fft.sv
test/hamming_windowed_radix2_fft_test.sv
